FILE: design/ptat_pkg.sv
// Shared constants, types and state codes for the playback time to atlas tile block.
// Used by ptat_smul, ptat_sdiv and playback_time_to_atlas_tile_top; depends on nothing.
package ptat_pkg;

  // Fixed point of the played time
  localparam int FRAC_BITS = 16;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 16;
  localparam int FRAME_W = 32;
  localparam int TILE_W  = 16;
  localparam int PAGE_W  = 16;
  localparam int POS_W   = 32;
  localparam int CFG_W   = 32;

  // Serial arithmetic sizes
  localparam int SCALED_W  = TIME_W + RATE_W;
  localparam int DIV_W     = SCALED_W;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int Q_STEPS   = SCALED_W - FRAC_BITS;

  // Stream payload sizes, padded to whole bytes
  localparam int IN_DATA_W  = ((TIME_W + 1 + 7) / 8) * 8;
  localparam int OUT_RAW_W  = FRAME_W + PAGE_W + 1 + POS_W + POS_W + 1;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_ACR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd6;

  // Configuration reset values
  localparam logic [RATE_W-1:0]  RST_RATE_NUM = 16'd30;
  localparam logic [RATE_W-1:0]  RST_ONE16    = 16'd1;
  localparam logic [FRAME_W-1:0] RST_ONE32    = 32'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_DIV_TIME,
    ST_DIV_PAGE,
    ST_DIV_TILE,
    ST_MUL_TILE,
    ST_FINISH
  } state_t;

  // Divider command and status
  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: design/playback_time_to_atlas_tile_top.sv
// Per tick: the time scaling multiply, three serial divisions (frame, page, tile position)
//   and the texel origin multiplies, one after another, with handoffs between them.
// One tick at a time: in_tready is high only in idle; the shared serial divider (one quotient
//   bit per cycle over three divisions) and the two shift-add multipliers are used in turn.
// A new tick is taken while the previous result still waits in the output register.
// Reset (rst_n low, synchronous): registers to their defaults, page 0 held, not finished.
module playback_time_to_atlas_tile_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] played_time, [32] audio_done, [39:33] zero
  input  logic [ptat_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] frame_number, [47:32] page_number, [48] load_request,
  // [80:49] tile_u, [112:81] tile_v, [113] done_res, [119:114] zero
  output logic [ptat_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration writes
  input  logic                               cfg_wr_en,
  input  logic [ptat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptat_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int PAD_W  = ptat_pkg::DIV_W - ptat_pkg::FRAME_W;
  localparam int OPAD_W = ptat_pkg::OUT_DATA_W - ptat_pkg::OUT_RAW_W;

  // Configuration registers
  logic [ptat_pkg::RATE_W-1:0]  rate_num_r;
  logic [ptat_pkg::RATE_W-1:0]  rate_den_r;
  logic [ptat_pkg::FRAME_W-1:0] total_frames_r;
  logic [ptat_pkg::TILE_W-1:0]  tiles_across_r;
  logic [ptat_pkg::TILE_W-1:0]  tiles_down_r;
  logic [ptat_pkg::TILE_W-1:0]  tile_width_r;
  logic [ptat_pkg::TILE_W-1:0]  tile_height_r;

  // Effective values: zero acts as one
  logic [ptat_pkg::RATE_W-1:0]  den_eff;
  logic [ptat_pkg::FRAME_W-1:0] count_eff;
  logic [ptat_pkg::TILE_W-1:0]  across_eff;
  logic [ptat_pkg::TILE_W-1:0]  down_eff;

  // Sequencer and per-tick state
  ptat_pkg::state_t             state_r;
  ptat_pkg::state_t             state_nxt;
  logic                         audio_done_r;
  logic [ptat_pkg::FRAME_W-1:0] frame_r;
  logic                         over_r;
  logic [ptat_pkg::PAGE_W-1:0]  page_r;
  logic [ptat_pkg::PAGE_W-1:0]  held_page_r;
  logic [ptat_pkg::FRAME_W-1:0] last_frame_r;
  logic                         ended_r;
  logic                         ended_nxt;

  // Output register
  logic                         out_valid_r;
  logic [ptat_pkg::FRAME_W-1:0] out_frame_r;
  logic [ptat_pkg::PAGE_W-1:0]  out_page_r;
  logic                         out_req_r;
  logic [ptat_pkg::POS_W-1:0]   out_u_r;
  logic [ptat_pkg::POS_W-1:0]   out_v_r;
  logic                         out_done_r;

  // Arithmetic units
  logic                                           mul_start;
  logic [ptat_pkg::TIME_W-1:0]                    mul_a_a;
  logic [ptat_pkg::RATE_W-1:0]                    mul_a_b;
  logic                                           mul_a_done;
  logic [ptat_pkg::SCALED_W-1:0]                  mul_a_prod;
  logic [ptat_pkg::TILE_W-1:0]                    mul_b_a;
  logic [ptat_pkg::TILE_W-1:0]                    mul_b_b;
  logic                                           mul_b_done;
  logic [2*ptat_pkg::TILE_W-1:0]                  mul_b_prod;
  ptat_pkg::div_cmd_t                             div_cmd;
  ptat_pkg::div_sts_t                             div_sts;
  logic [ptat_pkg::DIV_W-1:0]                     div_dividend;
  logic [ptat_pkg::DVS_W-1:0]                     div_divisor;
  logic [ptat_pkg::DIV_W-1:0]                     div_q;
  logic [ptat_pkg::DVS_W-1:0]                     div_rem;

  // Control outputs
  logic                         in_xfer;
  logic                         out_load;
  logic                         over;
  logic [ptat_pkg::FRAME_W-1:0] frame_sel;

  assign den_eff    = (rate_den_r == '0) ? ptat_pkg::RST_ONE16 : rate_den_r;
  assign count_eff  = (total_frames_r == '0) ? ptat_pkg::RST_ONE32 : total_frames_r;
  assign across_eff = (tiles_across_r == '0) ? ptat_pkg::RST_ONE16 : tiles_across_r;
  assign down_eff   = (tiles_down_r == '0) ? ptat_pkg::RST_ONE16 : tiles_down_r;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_num_r     <= ptat_pkg::RST_RATE_NUM;
      rate_den_r     <= ptat_pkg::RST_ONE16;
      total_frames_r <= ptat_pkg::RST_ONE32;
      tiles_across_r <= ptat_pkg::RST_ONE16;
      tiles_down_r   <= ptat_pkg::RST_ONE16;
      tile_width_r   <= ptat_pkg::RST_ONE16;
      tile_height_r  <= ptat_pkg::RST_ONE16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptat_pkg::REG_RATE_NUM:    rate_num_r     <= cfg_wdata[ptat_pkg::RATE_W-1:0];
        ptat_pkg::REG_RATE_DEN:    rate_den_r     <= cfg_wdata[ptat_pkg::RATE_W-1:0];
        ptat_pkg::REG_TOTAL_FRAME: total_frames_r <= cfg_wdata[ptat_pkg::FRAME_W-1:0];
        ptat_pkg::REG_TILES_ACR:   tiles_across_r <= cfg_wdata[ptat_pkg::TILE_W-1:0];
        ptat_pkg::REG_TILES_DOWN:  tiles_down_r   <= cfg_wdata[ptat_pkg::TILE_W-1:0];
        ptat_pkg::REG_TILE_WIDTH:  tile_width_r   <= cfg_wdata[ptat_pkg::TILE_W-1:0];
        ptat_pkg::REG_TILE_HEIGHT: tile_height_r  <= cfg_wdata[ptat_pkg::TILE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame quotient to the last frame; a finished block keeps its last frame
  always_comb begin
    over = div_q >= {{PAD_W{1'b0}}, count_eff};
    if (ended_r) begin
      frame_sel = last_frame_r;
    end else if (over) begin
      frame_sel = count_eff - ptat_pkg::FRAME_W'(1);
    end else begin
      frame_sel = div_q[ptat_pkg::FRAME_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptat_pkg::ST_IDLE:     if (in_tvalid) state_nxt = ptat_pkg::ST_MUL_RATE;
      ptat_pkg::ST_MUL_RATE: if (mul_a_done) state_nxt = ptat_pkg::ST_DIV_TIME;
      ptat_pkg::ST_DIV_TIME: if (div_sts.done) state_nxt = ptat_pkg::ST_DIV_PAGE;
      ptat_pkg::ST_DIV_PAGE: if (div_sts.done) state_nxt = ptat_pkg::ST_DIV_TILE;
      ptat_pkg::ST_DIV_TILE: if (div_sts.done) state_nxt = ptat_pkg::ST_MUL_TILE;
      ptat_pkg::ST_MUL_TILE: if (mul_a_done) state_nxt = ptat_pkg::ST_FINISH;
      ptat_pkg::ST_FINISH:   if (!out_valid_r || out_tready) state_nxt = ptat_pkg::ST_IDLE;
      default:               state_nxt = ptat_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: unit starts and operand selection
  always_comb begin
    in_tready     = 1'b0;
    out_load      = 1'b0;
    mul_start     = 1'b0;
    mul_a_a       = in_tdata[ptat_pkg::TIME_W-1:0];
    mul_a_b       = rate_num_r;
    mul_b_a       = across_eff;
    mul_b_b       = down_eff;
    div_cmd.start = 1'b0;
    div_cmd.steps = ptat_pkg::DIV_CNT_W'(ptat_pkg::FRAME_W);
    div_dividend  = {div_rem, {PAD_W{1'b0}}};
    div_divisor   = {{(ptat_pkg::DVS_W - ptat_pkg::TILE_W){1'b0}}, across_eff};
    case (state_r)
      ptat_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        mul_start = in_tvalid;
      end
      ptat_pkg::ST_MUL_RATE: begin
        // time * rate / (den << FRAC_BITS): drop the fraction bits, divide by den
        div_cmd.start = mul_a_done;
        div_cmd.steps = ptat_pkg::DIV_CNT_W'(ptat_pkg::Q_STEPS);
        div_dividend  = (mul_a_prod >> ptat_pkg::FRAC_BITS) << ptat_pkg::FRAC_BITS;
        div_divisor   = {{(ptat_pkg::DVS_W - ptat_pkg::RATE_W){1'b0}}, den_eff};
      end
      ptat_pkg::ST_DIV_TIME: begin
        // frame / tiles per page
        div_cmd.start = div_sts.done;
        div_dividend  = {frame_sel, {PAD_W{1'b0}}};
        div_divisor   = mul_b_prod;
      end
      ptat_pkg::ST_DIV_PAGE: begin
        // frame within page / tiles across
        div_cmd.start = div_sts.done;
      end
      ptat_pkg::ST_DIV_TILE: begin
        mul_start = div_sts.done;
        mul_a_a   = {{(ptat_pkg::TIME_W - ptat_pkg::TILE_W){1'b0}},
                     div_rem[ptat_pkg::TILE_W-1:0]};
        mul_a_b   = tile_width_r;
        mul_b_a   = div_q[ptat_pkg::TILE_W-1:0];
        mul_b_b   = tile_height_r;
      end
      ptat_pkg::ST_MUL_TILE: ;
      ptat_pkg::ST_FINISH: begin
        out_load = !out_valid_r || out_tready;
      end
      default: ;
    endcase
  end

  assign in_xfer   = in_tvalid && in_tready;
  assign ended_nxt = ended_r || (over_r && audio_done_r);

  // Sequencer and sticky state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptat_pkg::ST_IDLE;
      held_page_r  <= '0;
      last_frame_r <= '0;
      ended_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (!ended_r) begin
          held_page_r  <= page_r;
          last_frame_r <= frame_r;
          ended_r      <= ended_nxt;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-tick payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      audio_done_r <= in_tdata[ptat_pkg::TIME_W];
    end
    if (state_r == ptat_pkg::ST_DIV_TIME && div_sts.done) begin
      frame_r <= frame_sel;
      over_r  <= over && !ended_r;
    end
    if (state_r == ptat_pkg::ST_DIV_PAGE && div_sts.done) begin
      page_r <= div_q[ptat_pkg::PAGE_W-1:0];
    end
    if (out_load) begin
      out_frame_r <= frame_r;
      out_page_r  <= ended_r ? held_page_r : page_r;
      out_req_r   <= !ended_r && (page_r != held_page_r);
      out_u_r     <= mul_a_prod[ptat_pkg::POS_W-1:0];
      out_v_r     <= mul_b_prod;
      out_done_r  <= ended_nxt;
    end
  end

  // Time scaling and texel x origin
  ptat_smul #(
    .AW (ptat_pkg::TIME_W),
    .BW (ptat_pkg::RATE_W)
  ) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a_a),
    .b     (mul_a_b),
    .done  (mul_a_done),
    .prod  (mul_a_prod)
  );

  // Tiles per page and texel y origin
  ptat_smul #(
    .AW (ptat_pkg::TILE_W),
    .BW (ptat_pkg::TILE_W)
  ) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_b_a),
    .b     (mul_b_b),
    .done  (mul_b_done),
    .prod  (mul_b_prod)
  );

  // Shared divider: frame, page and tile position
  ptat_sdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OPAD_W{1'b0}}, out_done_r, out_v_r, out_u_r, out_req_r,
                       out_page_r, out_frame_r};

  // Both multipliers run in lockstep
  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mul_a_done == mul_b_done)
    else $error("multipliers out of step");

  // Divider is never restarted mid-division
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_cmd.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // A finished block repeats without requesting a page load
  a_ended_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && ended_r |=> !out_req_r && out_done_r)
    else $error("load request after finish");

  // Finished flag is sticky
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("finished flag cleared");

endmodule

FILE: design/ptat_smul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ptat_pkg for default widths.
module ptat_smul #(
  parameter int AW = ptat_pkg::TIME_W,
  parameter int BW = ptat_pkg::RATE_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [AW-1:0]  a,
  input  logic [BW-1:0]  b,
  output logic           done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0]    a_r;
  logic [AW+BW-1:0] p_r;
  logic [AW+BW-1:0] p_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [AW-1:0]    addend;
  logic [AW:0]      sum;

  // Add the multiplicand under the low multiplier bit, then shift right
  always_comb begin
    addend = p_r[0] ? a_r : '0;
    sum    = {1'b0, p_r[AW+BW-1:BW]} + {1'b0, addend};
    p_nxt  = {sum, p_r[BW-1:1]};
  end

  // Control: count multiplier bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then step
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{AW{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

FILE: design/ptat_sdiv.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Dividend is left-aligned; after N steps the low N bits hold the quotient. Uses ptat_pkg.
module ptat_sdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ptat_pkg::div_cmd_t           cmd,
  input  logic [ptat_pkg::DIV_W-1:0]   dividend,
  input  logic [ptat_pkg::DVS_W-1:0]   divisor,
  output ptat_pkg::div_sts_t           sts,
  output logic [ptat_pkg::DIV_W-1:0]   quot,
  output logic [ptat_pkg::DVS_W-1:0]   rem
);

  logic [ptat_pkg::DIV_W-1:0]     dq_r;
  logic [ptat_pkg::DVS_W-1:0]     rem_r;
  logic [ptat_pkg::DVS_W-1:0]     div_r;
  logic [ptat_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [ptat_pkg::DVS_W:0]       trial;
  logic [ptat_pkg::DVS_W+1:0]     diff;
  logic                           ge;
  logic [ptat_pkg::DVS_W-1:0]     rem_nxt;
  logic [ptat_pkg::DIV_W-1:0]     dq_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, dq_r[ptat_pkg::DIV_W-1]};
    diff    = {1'b0, trial} - {2'b00, div_r};
    ge      = !diff[ptat_pkg::DVS_W+1];
    rem_nxt = ge ? diff[ptat_pkg::DVS_W-1:0] : trial[ptat_pkg::DVS_W-1:0];
    dq_nxt  = {dq_r[ptat_pkg::DIV_W-2:0], ge};
  end

  // Control: run the requested number of steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ptat_pkg::DIV_CNT_W'(1);
        if (cnt_r == ptat_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load, then step; hold results while idle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = dq_r;
  assign rem      = rem_r;

endmodule
